@@ hdl/slt_pkg.sv @@
// Shared types and constants for the sequential list table.
`default_nettype none

package slt_pkg;

    // Default sizing handed to the top level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // Request opcodes, carried on s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_DELETE = 3'd1,
        FN_READ   = 3'd2,
        FN_WRITE  = 3'd3,
        FN_LOCATE = 3'd4,
        FN_CLEAR  = 3'd5
    } func_t;

    // Result status codes, carried on m_tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_POS  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_FND  = 2'd3
    } status_t;

    // Status and flag group passed from the sequencer to the output stage
    typedef struct packed {
        status_t status;
        logic    before_valid;
        logic    after_valid;
        logic    is_empty;
    } res_flags_t;

endpackage

`default_nettype wire

@@ hdl/sequential_list_table.sv @@
// Sequential list table top level: stream ports, store and output register.
//
// One request beat in on s_*, one result beat out on m_*. The opcode rides on
// s_tuser; position and value on s_tdata. The result status rides on m_tuser.
// The list lives in a single-port-write, single-port-read store, and insert,
// delete and locate walk it one entry per cycle through one address stepper.
// Insert and delete shift the entries after the position by one place;
// locate scans from the head until a match or the end of the list; read
// and write reach one entry; clear, a bad request and an unused opcode
// go straight to the result. s_tready rises together with m_tvalid when
// the result loads into the output register.
// s_tready is high only while no request is in work; one request at a time.
// A finished result waits in the output register while the next request is
// taken in; if a second result is ready before m_tready, the sequencer holds
// it and takes no more requests until the output register frees up.
// Reset empties the list and drops m_tvalid; stored entries keep stale data
// but are never read before being written.
`default_nettype none

module sequential_list_table #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF,
    parameter int POS_W      = $clog2(CAPACITY + 2),
    parameter int S_TDATA_W  = ((POS_W + DATA_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((3 * DATA_WIDTH + 2 * POS_W + 3 + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // request channel
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // position, value
    input  wire logic [S_TDATA_W-1:0]         s_tdata,
    // func
    input  wire logic [slt_pkg::FUNC_W-1:0]   s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // read_value, found_position, before_value, before_valid,
    // after_value, after_valid, count, is_empty
    output logic      [M_TDATA_W-1:0]         m_tdata,
    // status
    output logic      [slt_pkg::STATUS_W-1:0] m_tuser
);

    localparam int AW = $clog2(CAPACITY);

    logic                  done;
    logic                  take;
    logic [DATA_WIDTH-1:0] res_read_value;
    logic [POS_W-1:0]      res_found_pos;
    logic [DATA_WIDTH-1:0] res_before_value;
    logic [DATA_WIDTH-1:0] res_after_value;
    logic [POS_W-1:0]      res_count;
    slt_pkg::res_flags_t   res_flags;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]         m_tdata_reg;
    logic [slt_pkg::STATUS_W-1:0] m_tuser_reg;

    slt_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .POS_W      (POS_W)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_func          (s_tuser),
        .in_pos           (s_tdata[POS_W-1:0]),
        .in_val           (s_tdata[POS_W+DATA_WIDTH-1:POS_W]),
        .done             (done),
        .take             (take),
        .res_read_value   (res_read_value),
        .res_found_pos    (res_found_pos),
        .res_before_value (res_before_value),
        .res_after_value  (res_after_value),
        .res_count        (res_count),
        .res_flags        (res_flags),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

    slt_store #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: load when empty or being drained this cycle
    assign take          = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = (done && take) || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result beat payload
    always_ff @(posedge aclk) begin
        if (done && take) begin
            m_tuser_reg <= res_flags.status;
            m_tdata_reg <= M_TDATA_W'({res_flags.is_empty,
                                       res_count,
                                       res_flags.after_valid,
                                       res_after_value,
                                       res_flags.before_valid,
                                       res_before_value,
                                       res_found_pos,
                                       res_read_value});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ hdl/slt_store.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module slt_store #(
    parameter int DEPTH = slt_pkg::CAPACITY_DEF,
    parameter int WIDTH = slt_pkg::DATA_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data in the cycle after the address
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/slt_seq.sv @@
// Sequencer: decodes a request and walks the store one entry per cycle.
`default_nettype none

module slt_seq #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(CAPACITY),
    parameter int POS_W      = $clog2(CAPACITY + 2)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // request side
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [slt_pkg::FUNC_W-1:0] in_func,
    input  wire logic [POS_W-1:0]           in_pos,
    input  wire logic [DATA_WIDTH-1:0]      in_val,
    // result side
    output logic                            done,
    input  wire logic                       take,
    output logic      [DATA_WIDTH-1:0]      res_read_value,
    output logic      [POS_W-1:0]           res_found_pos,
    output logic      [DATA_WIDTH-1:0]      res_before_value,
    output logic      [DATA_WIDTH-1:0]      res_after_value,
    output logic      [POS_W-1:0]           res_count,
    output slt_pkg::res_flags_t             res_flags,
    // store port
    output logic                            mem_wr_en,
    output logic      [AW-1:0]              mem_wr_addr,
    output logic      [DATA_WIDTH-1:0]      mem_wr_data,
    output logic      [AW-1:0]              mem_rd_addr,
    input  wire logic [DATA_WIDTH-1:0]      mem_rd_data
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SHIFT_UP = 9'b000000010,
        S_SHIFT_DN = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_NEIGH    = 9'b000010000,
        S_RD       = 9'b000100000,
        S_RD_WAIT  = 9'b001000000,
        S_WR       = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [POS_W-1:0]      len_reg, len_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         tag_reg, tag_next;
    logic [POS_W-1:0]      rem_reg, rem_next;
    logic                  pend_reg, pend_next;

    slt_pkg::status_t      status_reg, status_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [POS_W-1:0]      fpos_reg, fpos_next;
    logic [DATA_WIDTH-1:0] bv_reg, bv_next;
    logic                  bok_reg, bok_next;
    logic [DATA_WIDTH-1:0] av_reg, av_next;
    logic                  aok_reg, aok_next;

    logic [AW-1:0]         pos_addr;
    logic                  step_up;
    logic [AW-1:0]         idx_step;
    logic                  rem_zero;
    logic                  hit;

    assign pos_addr = pos_reg[AW-1:0] - AW'(1);
    assign rem_zero = (rem_reg == '0);
    assign hit      = pend_reg && (mem_rd_data == val_reg);

    // Shared address stepper: down for insert shifting, up otherwise
    assign step_up  = (state_reg != S_SHIFT_UP);
    assign idx_step = step_up ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));

    // Next-state and datapath control
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        tag_next    = tag_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        fpos_next   = fpos_reg;
        bv_next     = bv_reg;
        bok_next    = bok_reg;
        av_next     = av_reg;
        aok_next    = aok_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tag_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    pos_next    = in_pos;
                    val_next    = in_val;
                    pend_next   = 1'b0;
                    status_next = slt_pkg::ST_OK;
                    rd_next     = '0;
                    fpos_next   = '0;
                    bv_next     = '0;
                    bok_next    = 1'b0;
                    av_next     = '0;
                    aok_next    = 1'b0;
                    state_next  = S_DONE;
                    case (slt_pkg::func_t'(in_func))
                        slt_pkg::FN_INSERT: begin
                            if (in_pos == '0 || in_pos > len_reg + POS_W'(1)) begin
                                status_next = slt_pkg::ST_BAD_POS;
                            end else if (len_reg == POS_W'(CAPACITY)) begin
                                status_next = slt_pkg::ST_FULL;
                            end else begin
                                idx_next   = len_reg[AW-1:0] - AW'(1);
                                rem_next   = len_reg - in_pos + POS_W'(1);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        slt_pkg::FN_DELETE: begin
                            if (in_pos == '0 || in_pos > len_reg) begin
                                status_next = slt_pkg::ST_BAD_POS;
                            end else begin
                                idx_next   = in_pos[AW-1:0];
                                rem_next   = len_reg - in_pos;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        slt_pkg::FN_READ: begin
                            if (in_pos == '0 || in_pos > len_reg) begin
                                status_next = slt_pkg::ST_BAD_POS;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        slt_pkg::FN_WRITE: begin
                            if (in_pos == '0 || in_pos > len_reg) begin
                                status_next = slt_pkg::ST_BAD_POS;
                            end else begin
                                state_next = S_WR;
                            end
                        end
                        slt_pkg::FN_LOCATE: begin
                            idx_next   = '0;
                            rem_next   = len_reg;
                            state_next = S_SCAN;
                        end
                        slt_pkg::FN_CLEAR: begin
                            len_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Insert and delete: read one entry and write the one read last cycle
            S_SHIFT_UP, S_SHIFT_DN: begin
                if (!rem_zero) begin
                    idx_next  = idx_step;
                    tag_next  = step_up ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                    rem_next  = rem_reg - POS_W'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    mem_wr_en = 1'b1;
                end else if (rem_zero) begin
                    if (state_reg == S_SHIFT_UP) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = pos_addr;
                        mem_wr_data = val_reg;
                        len_next    = len_reg + POS_W'(1);
                    end else begin
                        len_next = len_reg - POS_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            // Locate: compare the entry read last cycle, keep its predecessor
            S_SCAN: begin
                if (!rem_zero) begin
                    idx_next  = idx_step;
                    tag_next  = idx_reg;
                    rem_next  = rem_reg - POS_W'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (hit) begin
                    status_next = slt_pkg::ST_OK;
                    rd_next     = mem_rd_data;
                    fpos_next   = POS_W'(tag_reg) + POS_W'(1);
                    bok_next    = (tag_reg != '0);
                    if (tag_reg == '0) begin
                        bv_next = '0;
                    end
                    // successor read was issued this same cycle
                    aok_next    = !rem_zero;
                    state_next  = rem_zero ? S_DONE : S_NEIGH;
                end else begin
                    if (pend_reg) begin
                        bv_next = mem_rd_data;
                    end
                    if (rem_zero) begin
                        status_next = slt_pkg::ST_NOT_FND;
                        bv_next     = '0;
                        state_next  = S_DONE;
                    end
                end
            end

            S_NEIGH: begin
                av_next    = mem_rd_data;
                state_next = S_DONE;
            end

            S_RD: begin
                mem_rd_addr = pos_addr;
                state_next  = S_RD_WAIT;
            end

            S_RD_WAIT: begin
                rd_next    = mem_rd_data;
                state_next = S_DONE;
            end

            S_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_addr;
                mem_wr_data = val_reg;
                state_next  = S_DONE;
            end

            // Hold the result until the output register is free
            S_DONE: begin
                if (take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    // Working and result payload
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        tag_reg    <= tag_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        fpos_reg   <= fpos_next;
        bv_reg     <= bv_next;
        bok_reg    <= bok_next;
        av_reg     <= av_next;
        aok_reg    <= aok_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign res_read_value   = rd_reg;
    assign res_found_pos    = fpos_reg;
    assign res_before_value = bv_reg;
    assign res_after_value  = av_reg;
    assign res_count        = len_reg;

    always_comb begin
        res_flags.status       = status_reg;
        res_flags.before_valid = bok_reg;
        res_flags.after_valid  = aok_reg;
        res_flags.is_empty     = (len_reg == '0);
    end

endmodule

`default_nettype wire
